[hw/rtl/eqr_pkg.sv]
package eqr_pkg;

    // Number formats of the vertex and texture coordinates.
    localparam int COORD_W         = 16;
    localparam int COORD_FRAC_BITS = 14;
    localparam int UV_BITS         = 16;
    localparam int SMALL_THR_W     = 15;
    localparam int POLE_THR_W      = 29;
    localparam int CFG_DATA_W      = 29;
    localparam int CFG_IDX_W       = 1;

    // Squares of the coordinates.
    localparam int YSQ_W = 2 * COORD_FRAC_BITS + 1;
    localparam int SQ_W  = 2 * COORD_W - 1;
    localparam int TSQ_W = 2 * SMALL_THR_W;
    localparam int P2_W  = SQ_W + 1;
    localparam logic [YSQ_W-1:0] ONE_SQ = YSQ_W'(1) << (2 * COORD_FRAC_BITS);

    // Angles are held in turns: 2^32 is one full turn.
    localparam int ANG_W = 34;
    localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(1 << 30);
    localparam int UV_SHIFT = 32 - UV_BITS;

    // The elevation radicand, and the azimuth one off the poles, is scaled by four
    // to the power sixteen before the root, and its numerator by two to the sixteenth.
    localparam int RADIUS_SHIFT = 16;
    localparam int SMALL_SQRT_SHIFT = 30;
    localparam int DIV_SHIFT = 45;

    // Square root unit: one result bit per stage.
    localparam int SQRT_IN_W   = 62;
    localparam int SQRT_OUT_W  = 31;
    localparam int SQRT_STAGES = SQRT_OUT_W;

    // Vectoring rotator.
    localparam int CORD_W          = 36;
    localparam int CORDIC_STAGES   = 16;
    localparam int NORM_STEPS      = 5;
    localparam int NORM_LIMIT_BIT  = 30;
    localparam int CORDIC_LAT      = NORM_STEPS + CORDIC_STAGES;

    // Restoring divider for the small radius form: one quotient bit per stage.
    localparam int DIV_STAGES = 31;
    localparam int PAD_STAGES = DIV_STAGES - CORDIC_LAT;

    // Side information runs alongside the root, rotator and divider stages.
    localparam int TAP_SQRT = SQRT_STAGES;
    localparam int SIDE_LEN = SQRT_STAGES + DIV_STAGES + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMALL_RADIUS = 1'b0,
        CFG_POLE_THR     = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic                      pole;
        logic                      zflag;
        logic                      small_r;
        logic                      sat;
        logic                      dzero;
        logic                      x_le0;
        logic [COORD_W-1:0]        x_abs;
        logic [COORD_W-1:0]        z;
        logic [COORD_W-1:0]        yc;
    } side_t;

    function automatic logic signed [ANG_W-1:0] atan_turn(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:  v = ANG_W'(536870912);
            1:  v = ANG_W'(316933406);
            2:  v = ANG_W'(167458907);
            3:  v = ANG_W'(85004756);
            4:  v = ANG_W'(42667331);
            5:  v = ANG_W'(21354465);
            6:  v = ANG_W'(10679838);
            7:  v = ANG_W'(5340245);
            8:  v = ANG_W'(2670163);
            9:  v = ANG_W'(1335087);
            10: v = ANG_W'(667544);
            11: v = ANG_W'(333772);
            12: v = ANG_W'(166886);
            13: v = ANG_W'(83443);
            14: v = ANG_W'(41722);
            15: v = ANG_W'(20861);
            16: v = ANG_W'(10430);
            17: v = ANG_W'(5215);
            18: v = ANG_W'(2608);
            19: v = ANG_W'(1304);
            20: v = ANG_W'(652);
            21: v = ANG_W'(326);
            22: v = ANG_W'(163);
            23: v = ANG_W'(81);
            24: v = ANG_W'(41);
            25: v = ANG_W'(20);
            26: v = ANG_W'(10);
            27: v = ANG_W'(5);
            28: v = ANG_W'(3);
            29: v = ANG_W'(1);
            30: v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic int norm_shift(input int k);
        return 1 << (NORM_STEPS - 1 - k);
    endfunction

    function automatic logic signed [ANG_W-1:0] clamp_quarter(
        input logic signed [ANG_W-1:0] a
    );
        logic signed [ANG_W-1:0] r;
        if (a > QUARTER)
            r = QUARTER;
        else if (a < -QUARTER)
            r = -QUARTER;
        else
            r = a;
        return r;
    endfunction

    // Rounds a turn value to UV_BITS bits, half up, saturating at all ones.
    function automatic logic [UV_BITS-1:0] to_uv(input logic [ANG_W-1:0] turns);
        logic [ANG_W-1:0] r;
        r = (turns + (ANG_W'(1) << (UV_SHIFT - 1))) >> UV_SHIFT;
        if (r > ANG_W'({UV_BITS{1'b1}}))
            return '1;
        return r[UV_BITS-1:0];
    endfunction

endpackage

[hw/rtl/eqr_vtx_if.sv]
interface eqr_vtx_if import eqr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink (input valid, input coord_x, input coord_y, input coord_z,
                  output ready);
endinterface

[hw/rtl/eqr_uv_if.sv]
interface eqr_uv_if import eqr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [UV_BITS-1:0] u_coord;
    logic [UV_BITS-1:0] v_coord;

    modport source (output valid, output u_coord, output v_coord, input ready);
    modport sink (input valid, input u_coord, input v_coord, output ready);
endinterface

[hw/rtl/eqr_isqrt.sv]
// Pipelined floor square root, one result bit per stage.
module eqr_isqrt import eqr_pkg::*; (
    input  logic                  clk,
    input  logic                  en,
    input  logic [SQRT_IN_W-1:0]  radicand,
    output logic [SQRT_OUT_W-1:0] root
);

    logic [SQRT_IN_W-1:0] v_reg [SQRT_STAGES];
    logic [SQRT_IN_W-1:0] r_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [SQRT_IN_W-1:0] v_src;
        logic [SQRT_IN_W-1:0] r_src;
        logic [SQRT_IN_W-1:0] trial;
        logic [SQRT_IN_W-1:0] v_next;
        logic [SQRT_IN_W-1:0] r_next;

        if (k == 0) begin : g_first
            always_comb
            begin
                v_src = radicand;
                r_src = '0;
            end
        end else begin : g_rest
            always_comb
            begin
                v_src = v_reg[k-1];
                r_src = r_reg[k-1];
            end
        end

        always_comb
        begin
            trial = r_src + (SQRT_IN_W'(1) << (2 * (SQRT_STAGES - 1 - k)));
            if (v_src >= trial)
            begin
                v_next = v_src - trial;
                r_next = (r_src >> 1) + (SQRT_IN_W'(1) << (2 * (SQRT_STAGES - 1 - k)));
            end
            else
            begin
                v_next = v_src;
                r_next = r_src >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k] <= v_next;
                r_reg[k] <= r_next;
            end
        end
    end

    assign root = r_reg[SQRT_STAGES-1][SQRT_OUT_W-1:0];

endmodule

[hw/rtl/eqr_cordic.sv]
// Pipelined vectoring rotator giving atan2(b, a) in turns for a >= 0.
// The first stages scale both operands up so that the larger magnitude
// sits at the top of the working range; the angle is not clamped here.
module eqr_cordic import eqr_pkg::*; (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [CORD_W-1:0] b_in,
    input  logic signed [CORD_W-1:0] a_in,
    output logic signed [ANG_W-1:0]  ang
);

    logic signed [CORD_W-1:0] nb_reg [NORM_STEPS];
    logic signed [CORD_W-1:0] na_reg [NORM_STEPS];
    logic [CORD_W-1:0]        nm_reg [NORM_STEPS];
    logic                     nz_reg [NORM_STEPS];

    logic signed [CORD_W-1:0] rb_reg [CORDIC_STAGES];
    logic signed [CORD_W-1:0] ra_reg [CORDIC_STAGES];
    logic signed [ANG_W-1:0]  rg_reg [CORDIC_STAGES];
    logic                     rz_reg [CORDIC_STAGES];

    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        logic signed [CORD_W-1:0] b_src;
        logic signed [CORD_W-1:0] a_src;
        logic [CORD_W-1:0]        m_src;
        logic                     z_src;
        logic [CORD_W-1:0]        b_abs;

        if (k == 0) begin : g_first
            always_comb
            begin
                b_abs = b_in[CORD_W-1] ? CORD_W'(-b_in) : CORD_W'(b_in);
                b_src = b_in;
                a_src = a_in;
                m_src = (b_abs > CORD_W'(a_in)) ? b_abs : CORD_W'(a_in);
                z_src = (b_in == '0);
            end
        end else begin : g_rest
            always_comb
            begin
                b_abs = '0;
                b_src = nb_reg[k-1];
                a_src = na_reg[k-1];
                m_src = nm_reg[k-1];
                z_src = nz_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (m_src < (CORD_W'(1) << (NORM_LIMIT_BIT - norm_shift(k))))
                begin
                    nb_reg[k] <= b_src <<< norm_shift(k);
                    na_reg[k] <= a_src <<< norm_shift(k);
                    nm_reg[k] <= m_src << norm_shift(k);
                end
                else
                begin
                    nb_reg[k] <= b_src;
                    na_reg[k] <= a_src;
                    nm_reg[k] <= m_src;
                end
                nz_reg[k] <= z_src;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
        logic signed [CORD_W-1:0] b_src;
        logic signed [CORD_W-1:0] a_src;
        logic signed [ANG_W-1:0]  g_src;
        logic                     z_src;

        if (i == 0) begin : g_first
            always_comb
            begin
                b_src = nb_reg[NORM_STEPS-1];
                a_src = na_reg[NORM_STEPS-1];
                g_src = '0;
                z_src = nz_reg[NORM_STEPS-1];
            end
        end else begin : g_rest
            always_comb
            begin
                b_src = rb_reg[i-1];
                a_src = ra_reg[i-1];
                g_src = rg_reg[i-1];
                z_src = rz_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (b_src > 0)
                begin
                    ra_reg[i] <= a_src + (b_src >>> i);
                    rb_reg[i] <= b_src - (a_src >>> i);
                    rg_reg[i] <= g_src + atan_turn(i);
                end
                else
                begin
                    ra_reg[i] <= a_src - (b_src >>> i);
                    rb_reg[i] <= b_src + (a_src >>> i);
                    rg_reg[i] <= g_src - atan_turn(i);
                end
                rz_reg[i] <= z_src;
            end
        end
    end

    // A zero numerator gives a zero angle whatever the rotations did.
    assign ang = rz_reg[CORDIC_STAGES-1] ? '0 : rg_reg[CORDIC_STAGES-1];

endmodule

[hw/rtl/unit_vector_to_equirect_uv_core.sv]
// Channel   Dir  Contents                                Word accepted when
// vtx       in   coord_x, coord_y, coord_z (Q2.14)       vtx.valid && vtx.ready
// uv        out  u_coord, v_coord (Q0.16, saturating)    uv.valid && uv.ready
// cfg_*     in   cfg_index, cfg_wdata                    cfg_wr_en
//
// One word is accepted every cycle while the skid register is empty; a vertex
// passes the registers of stage A and stage B, the bit-per-stage square root
// (31 stages) and then the bit-per-stage divider (31 stages), which the two
// rotators run alongside, before its result word reaches the output register.
// rst_n clears the valid bits and restores the threshold registers; the
// datapath needs no reset and no clearing pass.
// The whole pipeline moves on one enable. A word that meets a stalled output
// drops into a skid register, and only a full skid register drops vtx.ready.
module unit_vector_to_equirect_uv_core import eqr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    eqr_vtx_if.sink               vtx,
    eqr_uv_if.source              uv
);

    // Configuration registers; the user must write them only while the block is idle (not enforced).
    logic [SMALL_THR_W-1:0] small_thr_reg;
    logic [POLE_THR_W-1:0]  pole_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_thr_reg <= SMALL_THR_W'(16);
            pole_thr_reg  <= POLE_THR_W'(256);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SMALL_RADIUS: small_thr_reg <= cfg_wdata[SMALL_THR_W-1:0];
                CFG_POLE_THR:     pole_thr_reg  <= cfg_wdata[POLE_THR_W-1:0];
                default:          ;
            endcase
        end
    end

    // The pipeline advances whenever the skid register is empty.
    logic skid_valid_reg;
    logic out_valid_reg;
    logic pipe_en;

    assign pipe_en   = !skid_valid_reg;
    assign vtx.ready = pipe_en;

    // Stage A: clamp y to the unit range and form the squares.
    logic                      a_valid_reg;
    logic signed [COORD_W-1:0] a_x_reg;
    logic signed [COORD_W-1:0] a_z_reg;
    logic signed [COORD_W-1:0] a_yc_reg;
    logic [YSQ_W-1:0]          a_yc_sq_reg;
    logic [SQ_W-1:0]           a_x_sq_reg;
    logic [SQ_W-1:0]           a_z_sq_reg;
    logic [TSQ_W-1:0]          a_t_sq_reg;

    logic signed [COORD_W-1:0]   yc_c;
    logic signed [2*COORD_W-1:0] yc_prod;
    logic signed [2*COORD_W-1:0] x_prod;
    logic signed [2*COORD_W-1:0] z_prod;
    logic [TSQ_W-1:0]            t_sq_c;

    always_comb
    begin
        if (vtx.coord_y > COORD_W'(1 << COORD_FRAC_BITS))
            yc_c = COORD_W'(1 << COORD_FRAC_BITS);
        else if (vtx.coord_y < -COORD_W'(1 << COORD_FRAC_BITS))
            yc_c = -COORD_W'(1 << COORD_FRAC_BITS);
        else
            yc_c = vtx.coord_y;
        yc_prod = yc_c * yc_c;
        x_prod  = vtx.coord_x * vtx.coord_x;
        z_prod  = vtx.coord_z * vtx.coord_z;
        t_sq_c  = TSQ_W'(small_thr_reg) * TSQ_W'(small_thr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (pipe_en)
            a_valid_reg <= vtx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a_x_reg     <= vtx.coord_x;
            a_z_reg     <= vtx.coord_z;
            a_yc_reg    <= yc_c;
            a_yc_sq_reg <= yc_prod[YSQ_W-1:0];
            a_x_sq_reg  <= x_prod[SQ_W-1:0];
            a_z_sq_reg  <= z_prod[SQ_W-1:0];
            a_t_sq_reg  <= t_sq_c;
        end
    end

    // Stage B: one minus y squared, the branch decisions and the radicands.
    // Away from the poles the azimuth radicand is (1 - y^2 - z^2); near them
    // it is the horizontal radius squared, used only by the small radius form.
    logic [YSQ_W-1:0]     d_c;
    logic [P2_W-1:0]      p2_c;
    logic [P2_W-1:0]      rem_c;
    logic                 pole_c;
    side_t                side_c;
    logic [SQRT_IN_W-1:0] th_rad_c;
    logic [SQRT_IN_W-1:0] ph_rad_c;

    always_comb
    begin
        d_c    = ONE_SQ - a_yc_sq_reg;
        p2_c   = P2_W'(a_x_sq_reg) + P2_W'(a_z_sq_reg);
        rem_c  = P2_W'(d_c) - P2_W'(a_z_sq_reg);
        pole_c = d_c < pole_thr_reg;

        side_c.pole    = pole_c;
        side_c.zflag   = (a_x_reg == '0) && (a_z_reg == '0);
        side_c.small_r = p2_c < P2_W'(a_t_sq_reg);
        side_c.sat     = a_z_sq_reg >= SQ_W'(d_c);
        side_c.dzero   = (d_c == '0);
        side_c.x_le0   = (a_x_reg <= 0);
        side_c.x_abs   = a_x_reg[COORD_W-1] ? COORD_W'(-a_x_reg) : COORD_W'(a_x_reg);
        side_c.z       = a_z_reg;
        side_c.yc      = a_yc_reg;

        th_rad_c = SQRT_IN_W'(d_c) << (2 * RADIUS_SHIFT);
        if (pole_c)
            ph_rad_c = SQRT_IN_W'(p2_c) << SMALL_SQRT_SHIFT;
        else
            ph_rad_c = SQRT_IN_W'(rem_c[YSQ_W-1:0]) << (2 * RADIUS_SHIFT);
    end

    logic [SQRT_IN_W-1:0] th_rad_reg;
    logic [SQRT_IN_W-1:0] ph_rad_reg;
    side_t                sd_reg [SIDE_LEN];
    logic [SIDE_LEN-1:0]  vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (pipe_en)
            vld_reg <= {vld_reg[SIDE_LEN-2:0], a_valid_reg};
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            th_rad_reg <= th_rad_c;
            ph_rad_reg <= ph_rad_c;
            sd_reg[0]  <= side_c;
            for (int k = 1; k < SIDE_LEN; k++)
                sd_reg[k] <= sd_reg[k-1];
        end
    end

    // Square roots of both radicands.
    logic [SQRT_OUT_W-1:0] th_root;
    logic [SQRT_OUT_W-1:0] ph_root;

    eqr_isqrt u_th_sqrt (
        .clk      (clk),
        .en       (pipe_en),
        .radicand (th_rad_reg),
        .root     (th_root)
    );

    eqr_isqrt u_ph_sqrt (
        .clk      (clk),
        .en       (pipe_en),
        .radicand (ph_rad_reg),
        .root     (ph_root)
    );

    // Rotator operands. Near the poles the azimuth is atan2(z, |x|); elsewhere
    // both angles are atan2 of the scaled numerator over the root.
    side_t                    tap;
    logic signed [CORD_W-1:0] th_b;
    logic signed [CORD_W-1:0] th_a;
    logic signed [CORD_W-1:0] ph_b;
    logic signed [CORD_W-1:0] ph_a;
    logic signed [ANG_W-1:0]  th_ang;
    logic signed [ANG_W-1:0]  ph_ang;

    always_comb
    begin
        tap  = sd_reg[TAP_SQRT];
        th_b = CORD_W'($signed(tap.yc)) <<< RADIUS_SHIFT;
        th_a = CORD_W'(th_root);
        if (tap.pole)
        begin
            ph_b = CORD_W'($signed(tap.z));
            ph_a = CORD_W'(tap.x_abs);
        end
        else
        begin
            ph_b = CORD_W'($signed(tap.z)) <<< RADIUS_SHIFT;
            ph_a = CORD_W'(ph_root);
        end
    end

    eqr_cordic u_th_cordic (
        .clk  (clk),
        .en   (pipe_en),
        .b_in (th_b),
        .a_in (th_a),
        .ang  (th_ang)
    );

    eqr_cordic u_ph_cordic (
        .clk  (clk),
        .en   (pipe_en),
        .b_in (ph_b),
        .a_in (ph_a),
        .ang  (ph_ang)
    );

    // The rotator angles wait here for the divider to finish.
    logic signed [ANG_W-1:0] th_pad_reg [PAD_STAGES];
    logic signed [ANG_W-1:0] ph_pad_reg [PAD_STAGES];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            th_pad_reg[0] <= th_ang;
            ph_pad_reg[0] <= ph_ang;
            for (int k = 1; k < PAD_STAGES; k++)
            begin
                th_pad_reg[k] <= th_pad_reg[k-1];
                ph_pad_reg[k] <= ph_pad_reg[k-1];
            end
        end
    end

    // Small radius form: |z| * 2^45 over the root of (x^2 + z^2) * 2^30.
    // The quotient stays below half a turn when this form is chosen, so
    // 31 quotient bits suffice before the clamp to a quarter turn.
    logic [SQRT_IN_W-1:0]  dv_rem_reg [DIV_STAGES];
    logic [SQRT_OUT_W-1:0] dv_den_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] dv_quo_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [SQRT_IN_W-1:0]  rem_src;
        logic [SQRT_OUT_W-1:0] den_src;
        logic [DIV_STAGES-1:0] quo_src;
        logic [SQRT_IN_W-1:0]  den_sh;
        logic [COORD_W-1:0]    z_abs;

        if (k == 0) begin : g_first
            always_comb
            begin
                z_abs   = tap.z[COORD_W-1] ? COORD_W'(-$signed(tap.z)) : tap.z;
                rem_src = SQRT_IN_W'(z_abs) << DIV_SHIFT;
                den_src = ph_root;
                quo_src = '0;
            end
        end else begin : g_rest
            always_comb
            begin
                z_abs   = '0;
                rem_src = dv_rem_reg[k-1];
                den_src = dv_den_reg[k-1];
                quo_src = dv_quo_reg[k-1];
            end
        end

        assign den_sh = SQRT_IN_W'(den_src) << (DIV_STAGES - 1 - k);

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                if (rem_src >= den_sh)
                begin
                    dv_rem_reg[k] <= rem_src - den_sh;
                    dv_quo_reg[k] <= quo_src | (DIV_STAGES'(1) << (DIV_STAGES - 1 - k));
                end
                else
                begin
                    dv_rem_reg[k] <= rem_src;
                    dv_quo_reg[k] <= quo_src;
                end
                dv_den_reg[k] <= den_src;
            end
        end
    end

    // Final selection of both angles and rounding to texture coordinates.
    side_t                   fin;
    logic signed [ANG_W-1:0] theta;
    logic signed [ANG_W-1:0] phi;
    logic signed [ANG_W-1:0] mag;
    logic signed [ANG_W-1:0] ut;
    logic signed [ANG_W-1:0] vt;
    logic [UV_BITS-1:0]      u_next;
    logic [UV_BITS-1:0]      v_next;

    always_comb
    begin
        fin = sd_reg[SIDE_LEN-1];

        // At the poles themselves the elevation is a quarter turn by the sign of y.
        if (fin.dzero)
        begin
            if ($signed(fin.yc) > 0)
                theta = QUARTER;
            else if ($signed(fin.yc) < 0)
                theta = -QUARTER;
            else
                theta = '0;
        end
        else
            theta = clamp_quarter(th_pad_reg[PAD_STAGES-1]);

        if (ANG_W'(dv_quo_reg[DIV_STAGES-1]) > QUARTER)
            mag = QUARTER;
        else
            mag = ANG_W'(dv_quo_reg[DIV_STAGES-1]);

        if (fin.pole)
        begin
            if (fin.zflag)
                phi = -QUARTER;
            else if (fin.small_r)
                phi = fin.z[COORD_W-1] ? -mag : mag;
            else
                phi = clamp_quarter(ph_pad_reg[PAD_STAGES-1]);
        end
        else if (fin.sat)
        begin
            // The ratio reaches one: a quarter turn by the sign of z.
            if ($signed(fin.z) > 0)
                phi = QUARTER;
            else if ($signed(fin.z) < 0)
                phi = -QUARTER;
            else
                phi = '0;
        end
        else
            phi = clamp_quarter(ph_pad_reg[PAD_STAGES-1]);

        if (fin.x_le0)
            ut = QUARTER - phi;
        else
            ut = QUARTER + QUARTER + QUARTER + phi;
        vt = (theta + QUARTER) <<< 1;

        u_next = to_uv(ut);
        v_next = to_uv(vt);
    end

    // Output register and skid register.
    logic [UV_BITS-1:0] out_u_reg;
    logic [UV_BITS-1:0] out_v_reg;
    logic [UV_BITS-1:0] skid_u_reg;
    logic [UV_BITS-1:0] skid_v_reg;
    logic               out_free;

    assign out_free = !out_valid_reg || uv.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (uv.ready)
                skid_valid_reg <= 1'b0;
        end
        else if (vld_reg[SIDE_LEN-1])
        begin
            if (out_free)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (uv.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (uv.ready)
            begin
                out_u_reg <= skid_u_reg;
                out_v_reg <= skid_v_reg;
            end
        end
        else if (vld_reg[SIDE_LEN-1])
        begin
            if (out_free)
            begin
                out_u_reg <= u_next;
                out_v_reg <= v_next;
            end
            else
            begin
                skid_u_reg <= u_next;
                skid_v_reg <= v_next;
            end
        end
    end

    assign uv.valid   = out_valid_reg;
    assign uv.u_coord = out_u_reg;
    assign uv.v_coord = out_v_reg;

`ifndef SYNTHESIS
    // A word in the skid register always has one ahead of it at the output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a word while the output is empty");

    // A frozen pipeline keeps every valid bit where it was.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(vld_reg))
        else $error("valid bits moved while the pipeline was stalled");

    // A finished word meeting a blocked output must land in the skid register.
    a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_en && vld_reg[SIDE_LEN-1] && out_valid_reg && !uv.ready)
        |=> skid_valid_reg)
        else $error("finished word lost at a blocked output");
`endif

endmodule
